[src/ddtks_pkg.sv]
package ddtks_pkg;

	localparam int VAL_W = 48;
	localparam int Q16_W = 17;
	localparam int EXP_W = 6;
	localparam int SUM_W = 52;
	localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [6:0] LEVEL_LIMIT_MAX = 7'd64;
	localparam logic [6:0] PERCENT_MAX = 7'd100;

	localparam logic [1:0] REG_LEVEL_LIMIT = 2'd0;
	localparam logic [1:0] REG_TOP_COUNT = 2'd1;
	localparam logic [1:0] REG_DECAY_PERCENT = 2'd2;

	typedef logic [Q16_W-1:0] decay_tab_t [0:127];

	// Decay factor in Q16 for every 7-bit percent code, rounded to nearest.
	function automatic decay_tab_t build_decay_tab();
		decay_tab_t t;
		int p;
		for (int i = 0; i < 128; i++) begin
			p = (i > 100) ? 100 : i;
			t[i] = Q16_W'((p * 65536 + 50) / 100);
		end
		return t;
	endfunction

	localparam decay_tab_t DECAY_TAB = build_decay_tab();

	typedef struct packed {
		logic             insert;
		logic             shift;
		logic             clear;
		logic [VAL_W-1:0] value;
	} ctrl_t;

	typedef struct packed {
		logic             valid;
		logic             ge;
		logic [VAL_W-1:0] value;
	} link_t;

endpackage

[src/ddtks_cell.sv]
module ddtks_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  ddtks_pkg::ctrl_t ctrl,
	input  ddtks_pkg::link_t prev_link,
	input  ddtks_pkg::link_t next_link,
	output ddtks_pkg::link_t link
);
	import ddtks_pkg::*;

	logic             valid_q;
	logic [VAL_W-1:0] value_q;
	logic             ge;

	assign ge = valid_q && (value_q >= ctrl.value);

	assign link.valid = valid_q;
	assign link.ge = ge;
	assign link.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_link.valid;
		end else if (ctrl.insert && !ge && prev_link.valid) begin
			valid_q <= 1'b1;
		end
	end

	// A cell whose value is below the new one takes the new value if its
	// left neighbor holds at least as much, and otherwise the neighbor's value.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_link.value;
		end else if (ctrl.insert && !ge) begin
			value_q <= prev_link.ge ? ctrl.value : prev_link.value;
		end
	end

endmodule

[src/ddtks_pow.sv]
module ddtks_pow (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [ddtks_pkg::Q16_W-1:0]   base,
	input  logic [ddtks_pkg::EXP_W-1:0]   expo,
	output logic [ddtks_pkg::Q16_W-1:0]   weight,
	output logic                          done
);
	import ddtks_pkg::*;

	logic [EXP_W-1:0]     exp_q;
	logic [Q16_W-1:0]     acc_q;
	logic [Q16_W-1:0]     base_q;
	logic [2*Q16_W-1:0]   acc_prod;
	logic [2*Q16_W-1:0]   base_prod;

	assign acc_prod = acc_q * base_q;
	assign base_prod = base_q * base_q;
	assign weight = acc_q;
	assign done = (exp_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (load) begin
			exp_q <= expo;
		end else if (!done) begin
			exp_q <= exp_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= ONE_Q16;
			base_q <= base;
		end else if (!done) begin
			if (exp_q[0]) begin
				acc_q <= acc_prod[16 +: Q16_W];
			end
			base_q <= base_prod[16 +: Q16_W];
		end
	end

endmodule

[src/decayed_depth_topk_sum.sv]
// An entry that is dropped leaves busy low, unless it is a last entry, which goes straight to summing.
// A kept entry keeps busy high through one square-and-multiply step per bit of its level (bit length 0 to 6),
// then one multiply state and one insertion state.
// A last entry adds a summing pass over k held values (k is the clamped top count); valid pulses the cycle after.
// A new entry is taken only while busy is low, so a kept entry, and a last entry's summing pass, must finish first.
// Reset clears the value chain and entry count and loads the registers with 40, 3 and 90.
module decayed_depth_topk_sum #(
	parameter int MAX_ENTRIES = 128,
	parameter int MAX_TOP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] quantity,
	input  logic [7:0]  level,
	input  logic        last_entry,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [6:0]  wr_data,
	output logic        valid,
	output logic [51:0] top_sum,
	output logic [7:0]  entries_kept
);
	import ddtks_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int KW = $clog2(MAX_TOP + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_POW  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_INS  = 5'b01000,
		ST_SUM  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [6:0]       level_limit_q;
	logic [4:0]       top_count_q;
	logic [6:0]       decay_percent_q;
	logic [31:0]      qty_q;
	logic             last_q;
	logic [CW-1:0]    entry_cnt_q;
	logic [VAL_W-1:0] prod_q;
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    sum_cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             valid_q;
	logic [SUM_W-1:0] top_sum_q;
	logic [7:0]       entries_kept_q;

	logic             accept;
	logic             kept;
	logic [6:0]       lim;
	logic [6:0]       tc7;
	logic [KW-1:0]    k_next;
	logic             pw_done;
	logic [Q16_W-1:0] pw_weight;
	logic [48:0]      prod_full;
	logic [SUM_W:0]   sum_nxt;
	logic             sum_done;
	ctrl_t            ctrl;
	link_t            link [MAX_TOP];
	link_t            head_link;
	link_t            tail_link;
	logic [MAX_TOP-1:0] valid_vec;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign lim = (level_limit_q > LEVEL_LIMIT_MAX) ? LEVEL_LIMIT_MAX : level_limit_q;
	assign kept = (level < {1'b0, lim}) && (entry_cnt_q < CW'(MAX_ENTRIES));
	assign tc7 = {2'b00, top_count_q};
	assign k_next = (tc7 > 7'(MAX_TOP)) ? KW'(MAX_TOP) : KW'(tc7);
	assign prod_full = {17'b0, qty_q} * {32'b0, pw_weight};
	assign sum_done = (sum_cnt_q == k_q);
	assign sum_nxt = {1'b0, sum_q} + {5'b0, link[0].value};

	assign valid = valid_q;
	assign top_sum = top_sum_q;
	assign entries_kept = entries_kept_q;

	ddtks_pow u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && kept),
		.base   (DECAY_TAB[decay_percent_q]),
		.expo   (level[EXP_W-1:0]),
		.weight (pw_weight),
		.done   (pw_done)
	);

	always_comb begin
		ctrl.insert = (state_q == ST_INS);
		ctrl.shift = (state_q == ST_SUM) && !sum_done;
		ctrl.clear = (state_q == ST_SUM) && sum_done;
		ctrl.value = prod_q;
	end

	assign head_link = '{valid: 1'b1, ge: 1'b1, value: '0};
	assign tail_link = '{valid: 1'b0, ge: 1'b0, value: '0};

	for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
		ddtks_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_link ((i == 0) ? head_link : link[(i == 0) ? 0 : i - 1]),
			.next_link ((i == MAX_TOP - 1) ? tail_link : link[(i == MAX_TOP - 1) ? i : i + 1]),
			.link      (link[i])
		);
		assign valid_vec[i] = link[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_limit_q <= 7'd40;
			top_count_q <= 5'd3;
			decay_percent_q <= 7'd90;
		end else if (wr_en) begin
			case (wr_index)
				REG_LEVEL_LIMIT: level_limit_q <= wr_data;
				REG_TOP_COUNT: top_count_q <= wr_data[4:0];
				REG_DECAY_PERCENT: decay_percent_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_cnt_q <= '0;
			last_q <= 1'b0;
			k_q <= '0;
			sum_cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_entry;
						k_q <= k_next;
						sum_cnt_q <= '0;
						if (kept) begin
							entry_cnt_q <= entry_cnt_q + 1'b1;
							state_q <= ST_POW;
						end else if (last_entry) begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_POW: begin
					if (pw_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					state_q <= last_q ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					if (sum_done) begin
						valid_q <= 1'b1;
						entry_cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sum_cnt_q <= sum_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qty_q <= quantity;
			sum_q <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[VAL_W-1:0];
		end
		if (ctrl.shift && link[0].valid) begin
			sum_q <= sum_nxt[SUM_W] ? {SUM_W{1'b1}} : sum_nxt[SUM_W-1:0];
		end
		if (ctrl.clear) begin
			top_sum_q <= sum_q;
			entries_kept_q <= 8'(entry_cnt_q);
		end
	end

	a_valid_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(state_q == ST_SUM))
		else $error("Result strobe without a summing pass.");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (entry_cnt_q == '0))
		else $error("Entry count not cleared with the result.");

	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("Held values are not packed toward the head of the chain.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CW'(MAX_ENTRIES))
		else $error("Entry count exceeds capacity.");

	a_sum_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (sum_cnt_q <= k_q))
		else $error("Summing pass ran past the top count.");

endmodule
